// ===== hdl/amr_pkg.sv =====
package amr_pkg;

    localparam int BYTE_W             = 8;
    localparam int FRAC_BITS_DEFAULT  = 16;
    localparam int ROM_DEPTH          = 256;

    localparam longint unsigned BYTE_MAX    = 64'd255;
    localparam longint unsigned W_RED_NUM   = 64'd2126;
    localparam longint unsigned W_GREEN_NUM = 64'd7152;
    localparam longint unsigned W_BLUE_NUM  = 64'd722;
    localparam longint unsigned W_DEN       = 64'd10000;
    localparam longint unsigned EPS_DEN     = 64'd1000;
    localparam longint unsigned MIX_NUM     = 64'd35;
    localparam longint unsigned MIX_DEN     = 64'd100;

endpackage

// ===== hdl/amr_pixel_if.sv =====
interface amr_pixel_if;

    logic                       valid;
    logic                       ready;
    logic [amr_pkg::BYTE_W-1:0] red;
    logic [amr_pkg::BYTE_W-1:0] green;
    logic [amr_pkg::BYTE_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// ===== hdl/amr_pbr_if.sv =====
interface amr_pbr_if;

    logic                       valid;
    logic                       ready;
    logic [amr_pkg::BYTE_W-1:0] metallic;
    logic [amr_pkg::BYTE_W-1:0] roughness;

    modport source (output valid, output metallic, output roughness, input ready);
    modport sink   (input valid, input metallic, input roughness, output ready);

endinterface

// ===== hdl/albedo_to_metal_rough_pixel_top.sv =====
// Albedo to metallic/roughness estimator, one RGB pixel per transaction.
//
// Channels: pix (sink) carries red, green and blue bytes; pbr (source)
// carries the metallic and roughness bytes. Both use valid/ready; a
// transaction completes on a rising edge with valid and ready high.
//
// Each accepted pixel is registered through every stage in turn before its result shows on pbr.
// Throughput: one pixel per cycle while the receiver does not stall; every stage then
// takes a new pixel each cycle and no stage has more than one multiply in series on its path.
//
// Reset (rst_n low, asynchronous) empties the pipeline; no result is shown.
// When the receiver stalls, the last stage holds its result and earlier
// stages keep advancing into empty slots, so bubbles close up; pix.ready
// falls only once every stage holds a pixel. Nothing is lost or repeated.
module albedo_to_metal_rough_pixel_top #(
    parameter int FRAC_BITS = amr_pkg::FRAC_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    amr_pixel_if.sink        pix,
    amr_pbr_if.source        pbr
);

    localparam int QW    = FRAC_BITS + 1;
    localparam int RW    = FRAC_BITS + 8;
    localparam int PW    = 2 * QW;
    localparam int SW    = 2 * QW + 1;
    localparam int EW    = QW + RW;
    localparam int TBW   = QW + 8;
    localparam int DEPTH = 9;

    localparam longint unsigned ONE   = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF  = 64'd1 << (FRAC_BITS - 1);
    localparam longint unsigned W_R   =
        (amr_pkg::W_RED_NUM * ONE + amr_pkg::W_DEN / 2) / amr_pkg::W_DEN;
    localparam longint unsigned W_G   =
        (amr_pkg::W_GREEN_NUM * ONE + amr_pkg::W_DEN / 2) / amr_pkg::W_DEN;
    localparam longint unsigned W_B   =
        (amr_pkg::W_BLUE_NUM * ONE + amr_pkg::W_DEN / 2) / amr_pkg::W_DEN;
    localparam longint unsigned EPS   =
        (ONE + amr_pkg::EPS_DEN / 2) / amr_pkg::EPS_DEN;
    localparam longint unsigned MIX   =
        (amr_pkg::MIX_NUM * ONE + amr_pkg::MIX_DEN / 2) / amr_pkg::MIX_DEN;

    localparam logic [QW-1:0] Q_ONE = QW'(ONE);
    localparam logic [QW-1:0] Q_EPS = QW'(EPS);

    function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [PW-1:0] p;
        p = PW'(a) * PW'(b) + PW'(HALF);
        return QW'(p >> FRAC_BITS);
    endfunction

    function automatic logic [amr_pkg::BYTE_W-1:0] to_byte(input logic [QW-1:0] x);
        logic [TBW-1:0] t;
        logic [TBW-1:0] s;
        t = TBW'(x) * TBW'(amr_pkg::BYTE_MAX);
        s = t >> FRAC_BITS;
        return (s > TBW'(amr_pkg::BYTE_MAX)) ? '1 : s[amr_pkg::BYTE_W-1:0];
    endfunction

    // Constant tables: channel byte to Q format, and reciprocal of the largest byte
    logic [QW-1:0] chan_rom  [amr_pkg::ROM_DEPTH];
    logic [RW-1:0] recip_rom [amr_pkg::ROM_DEPTH];

    for (genvar M = 0; M < amr_pkg::ROM_DEPTH; M++) begin : g_rom
        localparam longint unsigned DIV     = (M == 0) ? 64'd1 : longint'(M);
        localparam longint unsigned CHAN_V  =
            (longint'(M) * ONE + 64'd127) / amr_pkg::BYTE_MAX;
        localparam longint unsigned RECIP_V =
            (M == 0) ? 64'd0 : (amr_pkg::BYTE_MAX * ONE + DIV / 2) / DIV;
        assign chan_rom[M]  = QW'(CHAN_V);
        assign recip_rom[M] = RW'(RECIP_V);
    end

    // Flow control
    logic [DEPTH-1:0] v_reg;
    logic [DEPTH-1:0] v_next;
    logic [DEPTH-1:0] adv;

    always_comb
    begin
        adv[DEPTH-1] = !v_reg[DEPTH-1] || pbr.ready;
        for (int k = DEPTH - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        v_next = (v_reg & ~adv) | (adv & {v_reg[DEPTH-2:0], pix.valid});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign pix.ready = adv[0];
    assign pbr.valid = v_reg[DEPTH-1];

    // Stage 0: table lookups
    logic [amr_pkg::BYTE_W-1:0] maxb;
    logic [QW-1:0]              s0_r_reg, s0_g_reg, s0_b_reg;
    logic [RW-1:0]              s0_rcp_reg;
    logic                       s0_blk_reg;

    always_comb
    begin
        maxb = (pix.red > pix.green) ? pix.red : pix.green;
        if (pix.blue > maxb)
        begin
            maxb = pix.blue;
        end
    end

    // Stage 1: luminance and vibrance base
    logic [SW-1:0] lum_sum;
    logic [SW-1:0] lum_raw;
    logic [QW-1:0] gbmax;
    logic [QW-1:0] s1_lum_reg, s1_v_reg;
    logic [RW-1:0] s1_rcp_reg;
    logic          s1_blk_reg;

    always_comb
    begin
        lum_sum = SW'(QW'(W_R)) * SW'(s0_r_reg) + SW'(QW'(W_G)) * SW'(s0_g_reg)
                + SW'(QW'(W_B)) * SW'(s0_b_reg) + SW'(HALF);
        lum_raw = lum_sum >> FRAC_BITS;
        gbmax   = (s0_g_reg >= s0_b_reg) ? s0_g_reg : s0_b_reg;
    end

    // Stage 2: equality and vibrance
    logic [EW-1:0] eq_prod;
    logic [EW-1:0] eq_raw;
    logic [QW-1:0] s2_lum_reg, s2_eq_reg, s2_vib_reg;

    always_comb
    begin
        eq_prod = EW'(s1_lum_reg) * EW'(s1_rcp_reg) + EW'(HALF);
        eq_raw  = eq_prod >> FRAC_BITS;
    end

    // Stage 3: average term squared, roughness base
    logic [QW:0]   a_sum;
    logic [QW-1:0] a_val;
    logic [QW:0]   r2_sum;
    logic [QW-1:0] s3_a_reg, s3_a2_reg, s3_r2_reg;

    always_comb
    begin
        a_sum  = (QW+1)'(s2_eq_reg) + (QW+1)'(Q_ONE - s2_vib_reg);
        a_val  = a_sum[QW:1];
        r2_sum = (QW+1)'(Q_ONE - s2_lum_reg) + (QW+1)'(s2_eq_reg);
    end

    // Stage 4: cube, clamped
    logic [QW-1:0] k_raw;
    logic [QW-1:0] s4_k_reg, s4_r2_reg;

    assign k_raw = qmul(s3_a2_reg, s3_a_reg);

    // Stages 5 and 6: fourth power
    logic [QW-1:0] s5_m_reg, s5_r2_reg;
    logic [QW-1:0] metal_raw;
    logic [QW-1:0] s6_metal_reg, s6_r2_reg;

    assign metal_raw = qmul(s5_m_reg, s5_m_reg);

    // Stage 7: roughness mix
    logic [SW-1:0] rough_sum;
    logic [SW-1:0] rough_raw;
    logic [QW-1:0] s7_rough_reg, s7_metal_reg;

    always_comb
    begin
        rough_sum = SW'(s6_r2_reg) * SW'(QW'(ONE - MIX))
                  + SW'(Q_ONE - s6_metal_reg) * SW'(QW'(MIX)) + SW'(HALF);
        rough_raw = rough_sum >> FRAC_BITS;
    end

    // Stage 8: output bytes
    logic [amr_pkg::BYTE_W-1:0] s8_metallic_reg, s8_roughness_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_r_reg   <= chan_rom[pix.red];
            s0_g_reg   <= chan_rom[pix.green];
            s0_b_reg   <= chan_rom[pix.blue];
            s0_rcp_reg <= recip_rom[maxb];
            s0_blk_reg <= (maxb == '0);
        end
        if (adv[1])
        begin
            s1_lum_reg <= (lum_raw > SW'(ONE)) ? Q_ONE : QW'(lum_raw);
            s1_v_reg   <= (s0_r_reg >= gbmax) ? gbmax : s0_r_reg;
            s1_rcp_reg <= s0_rcp_reg;
            s1_blk_reg <= s0_blk_reg;
        end
        if (adv[2])
        begin
            s2_lum_reg <= s1_lum_reg;
            s2_eq_reg  <= (s1_blk_reg || eq_raw > EW'(ONE)) ? Q_ONE : QW'(eq_raw);
            s2_vib_reg <= qmul(s1_v_reg, s1_v_reg);
        end
        if (adv[3])
        begin
            s3_a_reg  <= a_val;
            s3_a2_reg <= qmul(a_val, a_val);
            s3_r2_reg <= Q_ONE - r2_sum[QW:1];
        end
        if (adv[4])
        begin
            if (k_raw < Q_EPS)
            begin
                s4_k_reg <= Q_EPS;
            end
            else if (k_raw > Q_ONE)
            begin
                s4_k_reg <= Q_ONE;
            end
            else
            begin
                s4_k_reg <= k_raw;
            end
            s4_r2_reg <= s3_r2_reg;
        end
        if (adv[5])
        begin
            s5_m_reg  <= qmul(s4_k_reg, s4_k_reg);
            s5_r2_reg <= s4_r2_reg;
        end
        if (adv[6])
        begin
            s6_metal_reg <= (metal_raw > Q_ONE) ? Q_ONE : metal_raw;
            s6_r2_reg    <= s5_r2_reg;
        end
        if (adv[7])
        begin
            s7_rough_reg <= (rough_raw > SW'(ONE)) ? Q_ONE : QW'(rough_raw);
            s7_metal_reg <= s6_metal_reg;
        end
        if (adv[8])
        begin
            s8_metallic_reg  <= to_byte(s7_metal_reg);
            s8_roughness_reg <= to_byte(s7_rough_reg);
        end
    end

    assign pbr.metallic  = s8_metallic_reg;
    assign pbr.roughness = s8_roughness_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready |=> v_reg[0])
        else $error("accepted pixel did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[DEPTH-2] && !adv[DEPTH-1] |=> v_reg[DEPTH-2] && v_reg[DEPTH-1])
        else $error("stalled stage dropped its pixel");

    a_eq_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] |-> s2_eq_reg <= Q_ONE && s2_lum_reg <= Q_ONE)
        else $error("equality or luminance above one");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[4] |-> s4_k_reg >= Q_EPS && s4_k_reg <= Q_ONE)
        else $error("cube term out of its clamp range");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[7] |-> s7_rough_reg <= Q_ONE && s7_metal_reg <= Q_ONE)
        else $error("result term above one");

endmodule
